[rtl/core/sync_framed_packet_receiver_assert.svh]
// Assertion macros shared by the receiver RTL.
`ifndef SYNC_FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define SYNC_FRAMED_PACKET_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/sfpr_pkg.sv]
`default_nettype none

package sfpr_pkg;

	localparam logic [31:0] SYNC_RESET = 32'hA5AA_BBA5;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_DONE    = 1'b1;

	typedef enum logic [4:0] {
		PH_HUNT    = 5'b00001,
		PH_ID      = 5'b00010,
		PH_LEN     = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CRC     = 5'b10000
	} sfpr_phase_t;

	typedef struct packed {
		logic        hit;
		logic        kind;
		logic [7:0]  data_byte;
		logic [7:0]  byte_index;
		logic [7:0]  cmd_code;
		logic [7:0]  payload_length;
		logic [31:0] received_crc;
	} sfpr_result_t;

endpackage

`default_nettype wire

[rtl/core/sync_framed_packet_receiver.sv]
`default_nettype none

// Sync-word framed packet receiver. Feed received bytes on rx_byte with
// in_valid/in_ready; the block hunts for the four-byte pattern held in the
// sync_pattern register (first byte in bits 31..24, reset 0xA5AABBA5), then
// takes a command byte, a length byte, that many payload bytes and four CRC
// bytes, least significant first. Every payload byte comes out as a kind 0
// transaction with its index; after the last CRC byte one kind 1 transaction
// carries the command, the length and the assembled CRC word, unchecked.
// Header, sync and non-final CRC bytes produce no output. The block takes one
// byte per clock while the output drains, passing it through one input
// register, then a single-pass state update that writes the output register.
// in_ready drops only while a byte with a result waits behind an output that
// is held by out_ready. Write cfg_wr_en/cfg_wr_data only while idle; the new
// pattern applies to the next hunt byte.

`include "sync_framed_packet_receiver_assert.svh"

module sync_framed_packet_receiver
	import sfpr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic [31:0]  cfg_wr_data,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   rx_byte,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic              kind,
	output logic [7:0]        data_byte,
	output logic [7:0]        byte_index,
	output logic [7:0]        cmd_code,
	output logic [7:0]        payload_length,
	output logic [31:0]       received_crc
);

	logic [31:0]   sync_q;
	logic          valid_s1;
	logic [7:0]    rx_s1;
	logic          adv_s1;
	sfpr_result_t  res;
	logic          out_valid_q;
	sfpr_result_t  out_q;

	// Configuration register, written without handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_wr_en) begin
			sync_q <= cfg_wr_data;
		end
	end

	// Advance the input stage when its byte makes no result or the output
	// register is free or being drained this cycle.
	assign adv_s1   = valid_s1 && (!res.hit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_s1 <= rx_byte;
		end
	end

	sfpr_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv_s1),
		.rx           (rx_s1),
		.sync_pattern (sync_q),
		.result       (res)
	);

	// Output register: load a new result, otherwise drop the one taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && res.hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.hit) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = out_q.kind;
	assign data_byte      = out_q.data_byte;
	assign byte_index     = out_q.byte_index;
	assign cmd_code       = out_q.cmd_code;
	assign payload_length = out_q.payload_length;
	assign received_crc   = out_q.received_crc;

	`SFPR_ASSERT_NEXT(a_result_lands, clk, arst_n,
		adv_s1 && res.hit, out_valid_q, "advanced result missing from output")
	`SFPR_ASSERT_NEXT(a_no_overwrite, clk, arst_n,
		out_valid_q && !out_ready && !(adv_s1 && res.hit), $stable(out_q),
		"held output changed")

endmodule

`default_nettype wire

[rtl/core/sfpr_core.sv]
`default_nettype none

`include "sync_framed_packet_receiver_assert.svh"

module sfpr_core
	import sfpr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic [7:0]   rx,
	input  wire logic [31:0]  sync_pattern,
	output sfpr_result_t      result
);

	sfpr_phase_t  phase_q, phase_d;
	logic [7:0]   cnt_q, cnt_d;
	logic [7:0]   cmd_q, cmd_d;
	logic [7:0]   len_q, len_d;
	logic [23:0]  acc_q, acc_d;
	logic [1:0]   pos;
	logic [7:0]   want;
	logic [8:0]   cnt_inc;

	assign pos     = cnt_q[1:0];
	assign want    = sync_pattern[{~pos, 3'b000} +: 8];
	assign cnt_inc = {1'b0, cnt_q} + 9'd1;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		cmd_d   = cmd_q;
		len_d   = len_q;
		acc_d   = acc_q;
		result  = '0;
		result.cmd_code       = cmd_q;
		result.payload_length = len_q;
		case (phase_q)
			PH_ID: begin
				cmd_d   = rx;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d   = rx;
				cnt_d   = '0;
				acc_d   = '0;
				phase_d = (rx == 8'd0) ? PH_CRC : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				result.hit        = 1'b1;
				result.kind       = KIND_PAYLOAD;
				result.data_byte  = rx;
				result.byte_index = cnt_q;
				cnt_d = cnt_inc[7:0];
				if (cnt_inc >= {1'b0, len_q}) begin
					cnt_d   = '0;
					phase_d = PH_CRC;
				end
			end
			PH_CRC: begin
				if (pos != 2'd3) begin
					acc_d = acc_q | (24'(rx) << {pos, 3'b000});
					cnt_d = {6'd0, pos + 2'd1};
				end else begin
					result.hit          = 1'b1;
					result.kind         = KIND_DONE;
					result.received_crc = {rx, acc_q};
					acc_d   = '0;
					cnt_d   = '0;
					phase_d = PH_HUNT;
				end
			end
			default: begin
				// Sync hunt; a mismatch restarts without retesting the byte.
				phase_d = PH_HUNT;
				if (rx == want) begin
					if (pos == 2'd3) begin
						cnt_d   = '0;
						phase_d = PH_ID;
					end else begin
						cnt_d = {6'd0, pos + 2'd1};
					end
				end else begin
					cnt_d = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= '0;
			cmd_q   <= '0;
			len_q   <= '0;
			acc_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			acc_q   <= acc_d;
		end
	end

	`SFPR_ASSERT_NEXT(a_done_rearms, clk, arst_n,
		step && result.hit && (result.kind == KIND_DONE),
		(phase_q == PH_HUNT) && (cnt_q == 8'd0), "packet end did not rearm the hunt")
	`SFPR_ASSERT_NOW(a_payload_in_range, clk, arst_n,
		phase_q == PH_PAYLOAD, cnt_q < len_q, "payload count reached the length")

endmodule

`default_nettype wire

[tb/sync_framed_packet_receiver_checker.sv]
module sync_framed_packet_receiver_checker
	import sfpr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  byte_index,
	input  logic [7:0]  cmd_code,
	input  logic [7:0]  payload_length,
	input  logic [31:0] received_crc,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Deframer shadow state.
	logic [31:0]  sync_word;
	sfpr_phase_t  rx_phase;
	logic [7:0]   byte_count;
	logic [7:0]   held_command;
	logic [7:0]   held_length;
	logic [23:0]  crc_low;

	sfpr_result_t expected_frames[$];
	sfpr_result_t want;
	sfpr_result_t got;
	int           mismatches;

	// Advance the shadow deframer by one byte; queue the result it causes.
	task automatic track_frame_byte(input logic [7:0] b);
		sfpr_result_t r;
		logic [1:0]   pos;
		logic [7:0]   sync_byte;
		r = '0;
		r.hit = 1'b1;
		r.cmd_code = held_command;
		r.payload_length = held_length;
		pos = byte_count[1:0];
		case (rx_phase)
			PH_ID: begin
				held_command = b;
				rx_phase = PH_LEN;
			end
			PH_LEN: begin
				held_length = b;
				byte_count = 8'd0;
				crc_low = 24'd0;
				rx_phase = (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				r.kind = KIND_PAYLOAD;
				r.data_byte = b;
				r.byte_index = byte_count;
				expected_frames.push_back(r);
				byte_count = byte_count + 8'd1;
				if (byte_count >= held_length) begin
					byte_count = 8'd0;
					rx_phase = PH_CRC;
				end
			end
			PH_CRC: begin
				if (pos != 2'd3) begin
					crc_low = crc_low | (24'(b) << (8 * pos));
					byte_count = {6'd0, pos} + 8'd1;
				end else begin
					r.kind = KIND_DONE;
					r.received_crc = {b, crc_low};
					expected_frames.push_back(r);
					crc_low = 24'd0;
					byte_count = 8'd0;
					rx_phase = PH_HUNT;
				end
			end
			default: begin
				// A miss drops the count without retrying the byte as a first sync byte.
				sync_byte = 8'(sync_word >> (8 * (3 - pos)));
				rx_phase = PH_HUNT;
				if (b == sync_byte) begin
					byte_count = {6'd0, pos} + 8'd1;
					if (byte_count >= 8'd4) begin
						byte_count = 8'd0;
						rx_phase = PH_ID;
					end
				end else begin
					byte_count = 8'd0;
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word = SYNC_RESET;
			rx_phase = PH_HUNT;
			byte_count = 8'd0;
			held_command = 8'd0;
			held_length = 8'd0;
			crc_low = 24'd0;
			expected_frames.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en)
				sync_word = cfg_wr_data;
			if (in_valid && in_ready)
				track_frame_byte(rx_byte);
			if (out_valid && out_ready) begin
				got = '0;
				got.hit = 1'b1;
				got.kind = kind;
				got.data_byte = data_byte;
				got.byte_index = byte_index;
				got.cmd_code = cmd_code;
				got.payload_length = payload_length;
				got.received_crc = received_crc;
				if (expected_frames.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected output kind=%0d data=%02h idx=%0d cmd=%02h len=%0d crc=%08h",
							$realtime, got.kind, got.data_byte, got.byte_index,
							got.cmd_code, got.payload_length, got.received_crc);
				end else begin
					want = expected_frames.pop_front();
					if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
							got.byte_index !== want.byte_index ||
							got.cmd_code !== want.cmd_code ||
							got.payload_length !== want.payload_length ||
							got.received_crc !== want.received_crc) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch expected kind=%0d data=%02h idx=%0d cmd=%02h len=%0d crc=%08h",
								$realtime, want.kind, want.data_byte, want.byte_index,
								want.cmd_code, want.payload_length, want.received_crc);
							$display("%0t:          actual   kind=%0d data=%02h idx=%0d cmd=%02h len=%0d crc=%08h",
								$realtime, got.kind, got.data_byte, got.byte_index,
								got.cmd_code, got.payload_length, got.received_crc);
						end
					end
				end
			end
			fail_count <= mismatches;
			pending <= expected_frames.size();
		end
	end

endmodule

[tb/sync_framed_packet_receiver_tb.sv]
module sync_framed_packet_receiver_tb;
	import sfpr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no transaction on either channel before the run is called hung.
	localparam int STALL_LIMIT = 5000;
	// Cycles to let a header or sync byte clear the pipeline before a register write.
	localparam int DRAIN_CYCLES = 8;
	// Length of the long output hold-off that backs the block up.
	localparam int HOLD_CYCLES = 400;
	// Byte budget of each random phase.
	localparam int PHASE_BYTES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = 32'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [7:0]  data_byte;
	logic [7:0]  byte_index;
	logic [7:0]  cmd_code;
	logic [7:0]  payload_length;
	logic [31:0] received_crc;

	int fail_count;
	int pending;

	// Idle odds in percent, changed per phase by the stimulus.
	int send_idle_pct = 25;
	int recv_idle_pct = 57;
	int phase_bytes;
	int stall_cycles = 0;
	logic hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sync_framed_packet_receiver u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.data_byte      (data_byte),
		.byte_index     (byte_index),
		.cmd_code       (cmd_code),
		.payload_length (payload_length),
		.received_crc   (received_crc)
	);

	sync_framed_packet_receiver_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.data_byte      (data_byte),
		.byte_index     (byte_index),
		.cmd_code       (cmd_code),
		.payload_length (payload_length),
		.received_crc   (received_crc),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	// Offer one byte and hold it until the block takes it. Random idle cycles
	// go in front of the byte, never between valid and its acceptance.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		phase_bytes++;
	endtask

	// Send one well-formed frame: sync word, command, length, payload, CRC.
	task automatic send_frame(input logic [31:0] sync, input logic [7:0] len);
		for (int i = 3; i >= 0; i--)
			send_byte(sync[8 * i +: 8]);
		send_byte(8'($urandom));
		send_byte(len);
		for (int i = 0; i < int'(len); i++)
			send_byte(8'($urandom));
		for (int i = 0; i < 4; i++)
			send_byte(8'($urandom));
	endtask

	// Write the pattern register only once the block has gone quiet: wait
	// for every expected output, then let any trailing header byte drain.
	task automatic write_sync_pattern(input logic [31:0] p);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= p;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Receiver side: random back-pressure, plus one long hold-off on request
	// so the block fills up and has to drop in_ready.
	initial begin : sink
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Watchdog: count cycles without any transaction and give up at the limit.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [31:0] pat;
		int          pick;
		int          k;
		logic [7:0]  len;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, on the reset pattern A5 AA BB A5.
		// Broken sync: the second A5 misses and is not retried as a first byte,
		// so only the trailing A5 AA BB A5 completes the sync.
		send_byte(8'hA5);
		send_byte(8'hA5);
		send_byte(8'hAA);
		send_byte(8'hBB);
		send_byte(8'hA5);
		send_byte(8'hAA);
		send_byte(8'hBB);
		send_byte(8'hA5);
		// Zero-length frame: straight from the length byte to the CRC bytes.
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		// One payload byte with all-ones content and CRC, zero command.
		for (int i = 3; i >= 0; i--)
			send_byte(SYNC_RESET[8 * i +: 8]);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'hFF);
		for (int i = 0; i < 4; i++)
			send_byte(8'hFF);

		// Random phases, each on a newly written pattern; the idle mix is set per pair of phases.
		for (int ph = 0; ph < 6; ph++) begin
			in_valid <= 1'b0;
			case (ph)
				1:       pat = 32'hFFFF_FFFF;
				2:       pat = 32'h0000_0000;
				4:       pat = SYNC_RESET;
				default: pat = $urandom;
			endcase
			write_sync_pattern(pat);

			if (ph < 2) begin
				send_idle_pct = 25;
				recv_idle_pct = 57;
			end else if (ph < 4) begin
				send_idle_pct = 57;
				recv_idle_pct = 25;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// Back the output up while the sender keeps pushing.
			if (ph == 4)
				hold_req <= 1'b1;

			phase_bytes = 0;
			// Cover the top payload index once with a full-length frame.
			if (ph == 5)
				send_frame(pat, 8'd255);
			while (phase_bytes < PHASE_BYTES) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					// Mostly short frames; a rare long one.
					if ($urandom_range(0, 59) == 0)
						len = 8'($urandom_range(128, 255));
					else
						len = 8'($urandom_range(0, 8));
					send_frame(pat, len);
				end else if (pick < 85) begin
					repeat ($urandom_range(1, 6))
						send_byte(8'($urandom));
				end else begin
					// Sync cut short by a byte that is sure to miss.
					k = $urandom_range(1, 3);
					for (int i = 0; i < k; i++)
						send_byte(pat[8 * (3 - i) +: 8]);
					send_byte(pat[8 * (3 - k) +: 8] ^ (8'd1 << $urandom_range(0, 7)));
				end
			end
		end
		in_valid <= 1'b0;

		// Drain: wait for every expected output, then watch for strays.
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/sfpr_pkg.sv
rtl/core/sfpr_core.sv
rtl/core/sync_framed_packet_receiver.sv
tb/sync_framed_packet_receiver_checker.sv
tb/sync_framed_packet_receiver_tb.sv
